FILE: sv/event_sort_queue_top_macros.svh
// assertion macros for the event sort queue
`ifndef EVENT_SORT_QUEUE_TOP_MACROS_SVH
`define EVENT_SORT_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define ESQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/esq_pkg.sv
// shared types and constants for the event sort queue
package esq_pkg;

    localparam int TIME_W  = 64;
    localparam int LEVEL_W = 8;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [LEVEL_W-1:0] nest_level;
        logic [TAG_W-1:0]   item_tag;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PLACE,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/esq_store.sv
// event store memory, one write port and one registered read port
module esq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  esq_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output esq_pkg::t_entry     o_rdata
);

    esq_pkg::t_entry r_mem [DEPTH];
    esq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/esq_cmp.sv
// key comparator: new event goes before a stored one
module esq_cmp (
    input  esq_pkg::t_entry i_new,
    input  esq_pkg::t_entry i_old,
    output logic            o_before
);

    logic lt_start;
    logic eq_start;

    assign lt_start = i_new.start_time < i_old.start_time;
    assign eq_start = i_new.start_time == i_old.start_time;
    assign o_before = lt_start || (eq_start && (i_new.nest_level > i_old.nest_level));

endmodule

FILE: sv/event_sort_queue_top.sv
// event sort queue top: insertion into a memory store, sorted burst on last item
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | start, busy          | i_start_time i_end_time i_nest_level i_item_tag
//          |                      | i_last_item
//  config  | i_cfg_we             | i_cfg_wdata
//  result  | o_valid              | o_out_start o_out_end o_out_level o_out_tag
//          |                      | o_end_bound o_overflowed o_last_out
//
// an item that is dropped or lands in an empty store is handled in idle,
// otherwise the single read port and comparator walk the store from the top
// one entry per cycle, moving each entry the new one goes before up one slot
// on a last item the store is read out one beat per cycle, each beat shown
// in the cycle after its read; busy covers the read cycles
// reset clears the control state and sets the limit to 64
// the receiver cannot stall, results are shown for one cycle each
`include "event_sort_queue_top_macros.svh"

module event_sort_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [esq_pkg::TIME_W-1:0]    i_start_time,
    input  logic [esq_pkg::TIME_W-1:0]    i_end_time,
    input  logic [esq_pkg::LEVEL_W-1:0]   i_nest_level,
    input  logic [esq_pkg::TAG_W-1:0]     i_item_tag,
    input  logic                          i_last_item,
    input  logic                          i_cfg_we,
    input  logic [esq_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    output logic                          o_valid,
    output logic [esq_pkg::TIME_W-1:0]    o_out_start,
    output logic [esq_pkg::TIME_W-1:0]    o_out_end,
    output logic [esq_pkg::LEVEL_W-1:0]   o_out_level,
    output logic [esq_pkg::TAG_W-1:0]     o_out_tag,
    output logic [esq_pkg::TIME_W-1:0]    o_end_bound,
    output logic                          o_overflowed,
    output logic                          o_last_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [esq_pkg::LIMIT_W-1:0] CAP_L = esq_pkg::LIMIT_W'(CAPACITY);

    esq_pkg::t_state r_state, n_state;
    logic [esq_pkg::LIMIT_W-1:0] r_limit;
    logic [CW-1:0]               r_fill, n_fill;
    logic [CW-1:0]               r_k, n_k;
    logic [AW-1:0]               r_idx, n_idx;
    logic [esq_pkg::TIME_W-1:0]  r_max, n_max;
    logic                        r_drop, n_drop;
    logic                        r_last, n_last;
    logic                        r_out_v, n_out_v;
    logic                        r_out_last, n_out_last;
    logic [esq_pkg::TIME_W-1:0]  r_out_bound;
    logic                        r_out_ovf;
    esq_pkg::t_entry             r_new;

    esq_pkg::t_entry in_entry;
    esq_pkg::t_entry rd_data;
    esq_pkg::t_entry wr_data;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic            accept;
    logic            full;
    logic            goes_first;

    assign in_entry = '{start_time: i_start_time, end_time: i_end_time,
                        nest_level: i_nest_level, item_tag: i_item_tag};
    assign accept   = start && !busy;
    assign busy     = (r_state != esq_pkg::ST_IDLE);
    assign full     = (esq_pkg::LIMIT_W'(r_fill) >= r_limit) ||
                      (esq_pkg::LIMIT_W'(r_fill) >= CAP_L);

    esq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    esq_cmp u_cmp (
        .i_new    (r_new),
        .i_old    (rd_data),
        .o_before (goes_first)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= esq_pkg::ST_IDLE;
            r_limit    <= esq_pkg::LIMIT_RESET;
            r_fill     <= '0;
            r_k        <= '0;
            r_idx      <= '0;
            r_max      <= '0;
            r_drop     <= 1'b0;
            r_last     <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_k        <= n_k;
            r_idx      <= n_idx;
            r_max      <= n_max;
            r_drop     <= n_drop;
            r_last     <= n_last;
            r_out_v    <= n_out_v;
            r_out_last <= n_out_last;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new <= in_entry;
        end
        if (r_state == esq_pkg::ST_EMIT) begin
            r_out_bound <= r_max;
            r_out_ovf   <= r_drop;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_k        = r_k;
        n_idx      = r_idx;
        n_max      = r_max;
        n_drop     = r_drop;
        n_last     = r_last;
        n_out_v    = 1'b0;
        n_out_last = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_k[AW-1:0];
        wr_data    = r_new;
        rd_addr    = r_idx;
        case (r_state)
            esq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_last = i_last_item;
                    n_idx  = '0;
                    if (full) begin
                        n_drop = 1'b1;
                        if (i_last_item) begin
                            if (r_fill == '0) begin
                                n_max  = '0;
                                n_drop = 1'b0;
                            end else begin
                                n_state = esq_pkg::ST_EMIT;
                            end
                        end
                    end else begin
                        if (i_end_time > r_max) begin
                            n_max = i_end_time;
                        end
                        if (r_fill == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = in_entry;
                            n_fill  = CW'(1);
                            if (i_last_item) begin
                                n_state = esq_pkg::ST_EMIT;
                            end
                        end else begin
                            n_k     = r_fill;
                            rd_addr = AW'(r_fill - CW'(1));
                            n_state = esq_pkg::ST_CMP;
                        end
                    end
                end
            end
            esq_pkg::ST_CMP: begin
                wr_en = 1'b1;
                if (goes_first) begin
                    wr_data = rd_data;
                    n_k     = r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        n_state = esq_pkg::ST_PLACE;
                    end else begin
                        rd_addr = AW'(r_k - CW'(2));
                    end
                end else begin
                    n_fill  = r_fill + CW'(1);
                    n_state = r_last ? esq_pkg::ST_EMIT : esq_pkg::ST_IDLE;
                end
            end
            esq_pkg::ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                n_fill  = r_fill + CW'(1);
                n_state = r_last ? esq_pkg::ST_EMIT : esq_pkg::ST_IDLE;
            end
            esq_pkg::ST_EMIT: begin
                n_out_v    = 1'b1;
                n_out_last = (r_idx == AW'(r_fill - CW'(1)));
                if (n_out_last) begin
                    n_state = esq_pkg::ST_IDLE;
                    n_fill  = '0;
                    n_max   = '0;
                    n_drop  = 1'b0;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = esq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_v;
    assign o_out_start  = rd_data.start_time;
    assign o_out_end    = rd_data.end_time;
    assign o_out_level  = rd_data.nest_level;
    assign o_out_tag    = rd_data.item_tag;
    assign o_end_bound  = r_out_bound;
    assign o_overflowed = r_out_ovf;
    assign o_last_out   = r_out_last;

    `ESQ_ASSERT_NOW(a_cmp_k_nonzero, i_clk, i_rst_n, r_state == esq_pkg::ST_CMP, r_k != '0, "compare step with empty slot index")
    `ESQ_ASSERT_NEXT(a_burst_runs, i_clk, i_rst_n, o_valid && !o_last_out, o_valid, "result burst broken before last beat")
    `ESQ_ASSERT_NEXT(a_last_leaves_idle, i_clk, i_rst_n, accept && i_last_item, busy || (r_fill == '0), "last item left stored events behind")
    `ESQ_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, esq_pkg::LIMIT_W'(r_fill) <= CAP_L, "fill count beyond capacity")

endmodule
